// File: hw/rtl/abnsc_pkg.sv
package abnsc_pkg;

   localparam int MAX_NAL_BYTES = 1048576;
   localparam int CNT_W = $clog2(MAX_NAL_BYTES + 2);
   localparam int LEN_W = 21;

   localparam logic [7:0] FORBID_MASK = 8'h80;
   localparam logic [7:0] REFIDC_MASK = 8'h60;
   localparam logic [7:0] TYPE_MASK = 8'h1f;

   localparam logic [4:0] NT_SLICE = 5'd1;
   localparam logic [4:0] NT_IDR = 5'd5;
   localparam logic [4:0] NT_SEI = 5'd6;
   localparam logic [4:0] NT_SPS = 5'd7;
   localparam logic [4:0] NT_PPS = 5'd8;

   localparam logic [2:0] FK_OTHER = 3'd0;
   localparam logic [2:0] FK_P = 3'd1;
   localparam logic [2:0] FK_B = 3'd2;
   localparam logic [2:0] FK_I = 3'd3;
   localparam logic [2:0] FK_SEI = 3'd4;
   localparam logic [2:0] FK_SPS = 3'd5;
   localparam logic [2:0] FK_PPS = 3'd6;

   localparam logic [1:0] GP_FM_PRE = 2'd0;
   localparam logic [1:0] GP_FM_SUF = 2'd1;
   localparam logic [1:0] GP_ST_PRE = 2'd2;
   localparam logic [1:0] GP_ST_SUF = 2'd3;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       stream_end;
   } req_type;

   typedef struct packed {
      logic [7:0]       out_byte;
      logic             first_of_nal;
      logic             last_of_nal;
      logic [2:0]       prefix_len;
      logic             forbidden_zero;
      logic [1:0]       ref_idc;
      logic [4:0]       nal_type;
      logic [2:0]       frame_kind;
      logic [LEN_W-1:0] nal_length;
      logic             length_overflow;
      logic             bad_start;
   } rsp_type;

   typedef struct packed {
      logic       bad;
      logic [1:0] zeros;
      logic       has_byte;
      logic [7:0] data;
      logic       close;
      logic       start;
      logic       pfx4;
   } cmd_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_BAD,
      OP_ZERO,
      OP_BYTE,
      OP_CLOSE
   } op_type;

   typedef struct packed {
      logic [1:0]  phase;
      logic [5:0]  zeros;
      logic [31:0] value;
      logic [2:0]  kind;
   } gol_type;

   function automatic logic [2:0] slice_class(input logic [31:0] value);
      logic [31:0] code;
      logic [2:0]  k;
      code = value - 32'd1;
      case (code)
         32'd0, 32'd3, 32'd5, 32'd8: k = FK_P;
         32'd1, 32'd6: k = FK_B;
         32'd2, 32'd4, 32'd7, 32'd9: k = FK_I;
         default: k = FK_OTHER;
      endcase
      return k;
   endfunction

   function automatic gol_type gol_bit(input gol_type g, input logic bit_in);
      gol_type    r;
      logic [5:0] n;
      r = g;
      n = g.zeros + {5'd0, ~bit_in};
      if (!(g.phase == GP_ST_SUF && g.zeros == 6'd0)) begin
         case (g.phase)
            GP_FM_PRE, GP_ST_PRE: begin
               if (!bit_in && g.zeros < 6'd31) begin
                  r.zeros = g.zeros + 6'd1;
               end else if (g.phase == GP_FM_PRE) begin
                  r.phase = (n == 6'd0) ? GP_ST_PRE : GP_FM_SUF;
                  r.zeros = n;
               end else begin
                  r.value = 32'd1;
                  r.phase = GP_ST_SUF;
                  r.zeros = n;
                  if (n == 6'd0) begin
                     r.kind = slice_class(32'd1);
                  end
               end
            end
            GP_FM_SUF: begin
               if (g.zeros != 6'd0) begin
                  r.zeros = g.zeros - 6'd1;
               end
               if (r.zeros == 6'd0) begin
                  r.phase = GP_ST_PRE;
               end
            end
            default: begin
               r.value = g.value[31] ? 32'hFFFF_FFFF : {g.value[30:0], bit_in};
               r.zeros = g.zeros - 6'd1;
               if (r.zeros == 6'd0) begin
                  r.kind = slice_class(r.value);
               end
            end
         endcase
      end
      return r;
   endfunction

   function automatic gol_type gol_byte(input gol_type g, input logic [7:0] b);
      gol_type r;
      r = g;
      for (int i = 7; i >= 0; i--) begin
         r = gol_bit(r, b[i]);
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/abnsc_front.sv
module abnsc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  abnsc_pkg::req_type req_data,
   output logic              cmd_push,
   output abnsc_pkg::cmd_type cmd_data
);
   import abnsc_pkg::*;

   logic [1:0] hc_ff, hc_in;
   logic       in_nal_ff, in_nal_in;
   logic       started_ff, started_in;
   logic [7:0] b;
   logic       is_start;

   assign b = req_data.in_byte;
   assign is_start = (b == 8'd1) && (hc_ff >= 2'd2);

   always_comb begin
      hc_in = hc_ff;
      in_nal_in = in_nal_ff;
      started_in = started_ff;
      cmd_data = '0;
      cmd_push = 1'b0;
      cmd_data.pfx4 = (hc_ff == 2'd3);
      if (accept) begin
         if (req_data.stream_end) begin
            if (in_nal_ff) begin
               cmd_data.zeros = hc_ff;
               cmd_data.close = 1'b1;
               cmd_push = 1'b1;
            end
            hc_in = 2'd0;
            in_nal_in = 1'b0;
            started_in = 1'b0;
         end else if (!started_ff) begin
            if (b == 8'd0 && hc_ff != 2'd3) begin
               hc_in = hc_ff + 2'd1;
            end else if (is_start) begin
               cmd_data.start = 1'b1;
               cmd_push = 1'b1;
               in_nal_in = 1'b1;
               started_in = 1'b1;
               hc_in = 2'd0;
            end else begin
               cmd_data.bad = 1'b1;
               cmd_push = 1'b1;
               started_in = 1'b1;
               if (b != 8'd0) begin
                  hc_in = 2'd0;
               end
            end
         end else if (in_nal_ff) begin
            if (b == 8'd0) begin
               if (hc_ff != 2'd3) begin
                  hc_in = hc_ff + 2'd1;
               end else begin
                  cmd_data.zeros = 2'd1;
                  cmd_push = 1'b1;
               end
            end else if (is_start) begin
               cmd_data.close = 1'b1;
               cmd_data.start = 1'b1;
               cmd_push = 1'b1;
               hc_in = 2'd0;
            end else begin
               cmd_data.zeros = hc_ff;
               cmd_data.has_byte = 1'b1;
               cmd_data.data = b;
               cmd_push = 1'b1;
               hc_in = 2'd0;
            end
         end else begin
            if (b == 8'd0) begin
               if (hc_ff != 2'd3) begin
                  hc_in = hc_ff + 2'd1;
               end
            end else if (is_start) begin
               cmd_data.start = 1'b1;
               cmd_push = 1'b1;
               in_nal_in = 1'b1;
               hc_in = 2'd0;
            end else begin
               hc_in = 2'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hc_ff <= 2'd0;
         in_nal_ff <= 1'b0;
         started_ff <= 1'b0;
      end else begin
         hc_ff <= hc_in;
         in_nal_ff <= in_nal_in;
         started_ff <= started_in;
      end
   end

endmodule

// File: hw/rtl/abnsc_cmd_queue.sv
module abnsc_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_push,
   input  abnsc_pkg::cmd_type q_din,
   output logic              q_full,
   input  logic              q_pop,
   output abnsc_pkg::cmd_type q_dout,
   output logic              q_empty
);
   import abnsc_pkg::*;

   cmd_type    mem_ff [2];
   logic       wp_ff, wp_in;
   logic       rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   assign q_full = (cnt_ff == 2'd2);
   assign q_empty = (cnt_ff == 2'd0);
   assign q_dout = mem_ff[rp_ff];

   always_comb begin
      wp_in = wp_ff + (q_push ? 1'b1 : 1'b0);
      rp_in = rp_ff + (q_pop ? 1'b1 : 1'b0);
      cnt_in = cnt_ff + (q_push ? 2'd1 : 2'd0) - (q_pop ? 2'd1 : 2'd0);
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         mem_ff[wp_ff] <= q_din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: hw/rtl/abnsc_back.sv
module abnsc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  abnsc_pkg::cmd_type q_dout,
   output logic              q_pop,
   output logic              empty,
   input  logic              pop,
   output abnsc_pkg::rsp_type rsp_data
);
   import abnsc_pkg::*;

   cmd_type          cur_ff, cur_in;
   logic             cur_vld_ff, cur_vld_in;
   logic [7:0]       hdr_ff, hdr_in;
   logic [7:0]       held_ff, held_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [2:0]       pfx_ff, pfx_in;
   gol_type          gol_ff, gol_in;

   rsp_type          rf_ff [2];
   logic             owp_ff, orp_ff;
   logic [1:0]       ocnt_ff, ocnt_in;
   logic             opush;
   rsp_type          res;

   op_type           op;
   logic             go;
   logic             done;
   logic [7:0]       cb;
   logic [4:0]       t;
   logic             slice;
   logic             over;
   logic [CNT_W-1:0] sat;
   logic             do_pop;

   assign t = hdr_ff[4:0];
   assign slice = (t == NT_SLICE) || (t == NT_IDR);
   assign over = cnt_ff > CNT_W'(MAX_NAL_BYTES);
   assign sat = over ? CNT_W'(MAX_NAL_BYTES) : cnt_ff;
   assign go = cur_vld_ff && (ocnt_ff != 2'd2);
   assign do_pop = pop && (ocnt_ff != 2'd0);

   always_comb begin
      if (!cur_vld_ff) begin
         op = OP_NONE;
      end else if (cur_ff.bad) begin
         op = OP_BAD;
      end else if (cur_ff.zeros != 2'd0) begin
         op = OP_ZERO;
      end else if (cur_ff.has_byte) begin
         op = OP_BYTE;
      end else begin
         op = OP_CLOSE;
      end
   end

   always_comb begin
      cur_in = cur_ff;
      cur_vld_in = cur_vld_ff;
      hdr_in = hdr_ff;
      held_in = held_ff;
      cnt_in = cnt_ff;
      pfx_in = pfx_ff;
      gol_in = gol_ff;
      res = '0;
      opush = 1'b0;
      q_pop = 1'b0;
      cb = (op == OP_BYTE) ? cur_ff.data : 8'd0;
      if (go) begin
         case (op)
            OP_BAD: begin
               res.bad_start = 1'b1;
               opush = 1'b1;
               cur_in.bad = 1'b0;
            end
            OP_ZERO, OP_BYTE: begin
               if (cnt_ff != '0) begin
                  res.out_byte = held_ff;
                  res.first_of_nal = (cnt_ff == CNT_W'(1));
                  opush = 1'b1;
                  if (slice) begin
                     gol_in = gol_byte(gol_ff, cb);
                  end
               end else begin
                  hdr_in = cb;
               end
               held_in = cb;
               if (!over) begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               if (op == OP_ZERO) begin
                  cur_in.zeros = cur_ff.zeros - 2'd1;
               end else begin
                  cur_in.has_byte = 1'b0;
               end
            end
            OP_CLOSE: begin
               if (cur_ff.close && cnt_ff != '0) begin
                  res.out_byte = held_ff;
                  res.first_of_nal = (cnt_ff == CNT_W'(1));
                  res.last_of_nal = 1'b1;
                  res.prefix_len = pfx_ff;
                  res.forbidden_zero = |(hdr_ff & FORBID_MASK);
                  res.ref_idc = hdr_ff[6:5] & REFIDC_MASK[6:5];
                  res.nal_type = hdr_ff[4:0] & TYPE_MASK[4:0];
                  case (t)
                     NT_SLICE, NT_IDR: res.frame_kind = gol_ff.kind;
                     NT_SEI: res.frame_kind = FK_SEI;
                     NT_SPS: res.frame_kind = FK_SPS;
                     NT_PPS: res.frame_kind = FK_PPS;
                     default: res.frame_kind = FK_OTHER;
                  endcase
                  res.nal_length = LEN_W'(sat);
                  res.length_overflow = over;
                  opush = 1'b1;
               end
               cnt_in = '0;
               if (cur_ff.start) begin
                  pfx_in = cur_ff.pfx4 ? 3'd4 : 3'd3;
                  hdr_in = 8'd0;
                  held_in = 8'd0;
                  gol_in = '0;
               end
               cur_in.close = 1'b0;
               cur_in.start = 1'b0;
            end
            default: begin
            end
         endcase
      end
      done = !(cur_in.bad || cur_in.zeros != 2'd0 || cur_in.has_byte
               || cur_in.close || cur_in.start);
      if (!cur_vld_ff || (go && done)) begin
         q_pop = !q_empty;
         cur_vld_in = !q_empty;
         cur_in = q_dout;
      end
      ocnt_in = ocnt_ff + (opush ? 2'd1 : 2'd0) - (do_pop ? 2'd1 : 2'd0);
   end

   assign empty = (ocnt_ff == 2'd0);
   assign rsp_data = rf_ff[orp_ff];

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      hdr_ff <= hdr_in;
      held_ff <= held_in;
      gol_ff <= gol_in;
      if (opush) begin
         rf_ff[owp_ff] <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_vld_ff <= 1'b0;
         cnt_ff <= '0;
         pfx_ff <= 3'd3;
         owp_ff <= 1'b0;
         orp_ff <= 1'b0;
         ocnt_ff <= 2'd0;
      end else begin
         cur_vld_ff <= cur_vld_in;
         cnt_ff <= cnt_in;
         pfx_ff <= pfx_in;
         owp_ff <= owp_ff + (opush ? 1'b1 : 1'b0);
         orp_ff <= orp_ff + (do_pop ? 1'b1 : 1'b0);
         ocnt_ff <= ocnt_in;
      end
   end

endmodule

// File: hw/rtl/annexb_nal_splitter_classifier_core.sv
// A byte's result passes the command queue, the current command and the result queue.
// Throughput: one byte per cycle unless full; the back end executes one confirm,
// close or bad-start step per cycle while the result queue has room.
// The exp-Golomb slice header read advances 8 bits per confirm step.
// Reset: synchronous; empties both queues and returns the parser to stream start.
module annexb_nal_splitter_classifier_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  abnsc_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output abnsc_pkg::rsp_type rsp_data
);
   import abnsc_pkg::*;

   logic    accept;
   logic    cmd_push;
   cmd_type cmd_data;
   logic    q_full;
   logic    q_pop;
   logic    q_empty;
   cmd_type q_dout;

   assign full = q_full;
   assign accept = push && !q_full;

   abnsc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .cmd_push (cmd_push),
      .cmd_data (cmd_data)
   );

   abnsc_cmd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (cmd_push),
      .q_din   (cmd_data),
      .q_full  (q_full),
      .q_pop   (q_pop),
      .q_dout  (q_dout),
      .q_empty (q_empty)
   );

   abnsc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_dout   (q_dout),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   a_mid_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_data.last_of_nal) |->
         (rsp_data.nal_length == '0 && rsp_data.frame_kind == FK_OTHER
          && rsp_data.prefix_len == 3'd0))
      else $error("summary fields set on a non-final transaction");

   a_bad_clean: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.bad_start) |->
         (rsp_data.out_byte == 8'd0 && !rsp_data.first_of_nal && !rsp_data.last_of_nal))
      else $error("bad_start transaction carries payload");

   a_prefix_len: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.last_of_nal) |->
         (rsp_data.prefix_len == 3'd3 || rsp_data.prefix_len == 3'd4))
      else $error("illegal prefix length on final transaction");

endmodule

// File: bench/tb_annexb_nal_splitter_classifier_core.sv
`timescale 1ns / 1ps

module tb_annexb_nal_splitter_classifier_core;
   import abnsc_pkg::*;

   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 16;
   localparam int NUM_RANDOM = 460;

   logic    clock;
   logic    reset;
   logic    push;
   logic    full;
   req_type req_data;
   logic    empty;
   logic    pop;
   rsp_type rsp_data;

   annexb_nal_splitter_classifier_core dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_data(req_data),
      .empty(empty),
      .pop(pop),
      .rsp_data(rsp_data)
   );

   // parser state of the predictor
   logic [7:0]  pend_byte;
   int          zero_run;
   bit          nal_open;
   bit          started;
   logic [2:0]  open_prefix;
   logic [7:0]  nal_header;
   int unsigned nal_bytes;
   logic [1:0]  gp_phase;
   int unsigned gp_zeros;
   logic [31:0] gp_value;
   logic [2:0]  gp_kind;

   rsp_type expected_rsp[$];
   int      error_count;
   int      idle_count;
   bit      rx_hold;
   bit      rx_calm;
   bit      tx_calm;

   typedef struct {
      logic [7:0] data;
      bit         fin;
      bit         typed;
      rsp_type    rsp;
   } row_type;

   row_type rows[$];

   task automatic report(input string what, input rsp_type got, input rsp_type want);
      error_count++;
      $display("mismatch %s: got %h want %h", what, got, want);
   endtask

   function automatic void parser_reset();
      pend_byte = 0; zero_run = 0; nal_open = 0; started = 0;
      open_prefix = 3'd3; nal_header = 0; nal_bytes = 0;
      gp_phase = GP_FM_PRE; gp_zeros = 0; gp_value = 0; gp_kind = FK_OTHER;
   endfunction

   function automatic logic [2:0] classify(input logic [31:0] v);
      logic [31:0] c;
      c = v - 32'd1;
      case (c)
         0, 3, 5, 8: return FK_P;
         1, 6: return FK_B;
         2, 4, 7, 9: return FK_I;
         default: return FK_OTHER;
      endcase
   endfunction

   function automatic void slice_bit(input bit b);
      int unsigned n;
      if (gp_phase == GP_ST_SUF && gp_zeros == 0) return;
      if (gp_phase == GP_FM_PRE || gp_phase == GP_ST_PRE) begin
         if (!b && gp_zeros < 31) begin
            gp_zeros++;
            return;
         end
         n = gp_zeros + (b ? 0 : 1);
         if (gp_phase == GP_FM_PRE) begin
            gp_phase = (n == 0) ? GP_ST_PRE : GP_FM_SUF;
            gp_zeros = n;
         end else begin
            gp_value = 1;
            gp_phase = GP_ST_SUF;
            gp_zeros = n;
            if (n == 0) gp_kind = classify(gp_value);
         end
      end else if (gp_phase == GP_FM_SUF) begin
         if (gp_zeros != 0) gp_zeros--;
         if (gp_zeros == 0) gp_phase = GP_ST_PRE;
      end else begin
         gp_value = gp_value[31] ? 32'hFFFF_FFFF : {gp_value[30:0], b};
         gp_zeros--;
         if (gp_zeros == 0) gp_kind = classify(gp_value);
      end
   endfunction

   function automatic void emit(input logic [7:0] b, input bit first, input bit last,
                                input bit bad);
      rsp_type r;
      logic [4:0] t;
      r = '0;
      r.out_byte = b;
      r.first_of_nal = first;
      r.last_of_nal = last;
      r.bad_start = bad;
      t = nal_header[4:0];
      if (last) begin
         r.prefix_len = open_prefix;
         r.forbidden_zero = nal_header[7];
         r.ref_idc = nal_header[6:5];
         r.nal_type = t;
         if (t == NT_SLICE || t == NT_IDR) r.frame_kind = gp_kind;
         else if (t == NT_SEI) r.frame_kind = FK_SEI;
         else if (t == NT_SPS) r.frame_kind = FK_SPS;
         else if (t == NT_PPS) r.frame_kind = FK_PPS;
         r.nal_length = LEN_W'((nal_bytes > MAX_NAL_BYTES) ? MAX_NAL_BYTES : nal_bytes);
         r.length_overflow = nal_bytes > MAX_NAL_BYTES;
      end
      expected_rsp.push_back(r);
   endfunction

   function automatic void confirm(input logic [7:0] b);
      logic [4:0] t;
      t = nal_header[4:0];
      if (nal_bytes != 0) begin
         emit(pend_byte, nal_bytes == 1, 0, 0);
         if (t == NT_SLICE || t == NT_IDR)
            for (int i = 7; i >= 0; i--) slice_bit(b[i]);
      end else begin
         nal_header = b;
      end
      pend_byte = b;
      if (nal_bytes <= MAX_NAL_BYTES) nal_bytes++;
   endfunction

   function automatic void close_open();
      if (nal_bytes != 0) emit(pend_byte, nal_bytes == 1, 1, 0);
      nal_open = 0; nal_bytes = 0; zero_run = 0;
   endfunction

   function automatic void open_nal(input int zeros);
      nal_open = 1; started = 1;
      open_prefix = (zeros == 3) ? 3'd4 : 3'd3;
      nal_header = 0; nal_bytes = 0; pend_byte = 0; zero_run = 0;
      gp_phase = GP_FM_PRE; gp_zeros = 0; gp_value = 0; gp_kind = FK_OTHER;
   endfunction

   function automatic void predict_nal_split(input req_type q);
      logic [7:0] b;
      b = q.in_byte;
      if (q.stream_end) begin
         if (nal_open) begin
            while (zero_run > 0) begin confirm(0); zero_run--; end
            close_open();
         end
         parser_reset();
      end else if (!started) begin
         if (b == 0 && zero_run < 3) zero_run++;
         else if (b == 1 && zero_run >= 2) open_nal(zero_run);
         else begin
            emit(0, 0, 0, 1);
            started = 1;
            if (b != 0) zero_run = 0;
         end
      end else if (nal_open) begin
         if (b == 0) begin
            if (zero_run < 3) zero_run++;
            else confirm(0);
         end else if (b == 1 && zero_run >= 2) begin
            int z;
            z = zero_run;
            close_open();
            open_nal(z);
         end else begin
            while (zero_run > 0) begin confirm(0); zero_run--; end
            confirm(b);
         end
      end else begin
         if (b == 0) begin
            if (zero_run < 3) zero_run++;
         end else if (b == 1 && zero_run >= 2) open_nal(zero_run);
         else zero_run = 0;
      end
   endfunction

   function automatic void add_row(input logic [7:0] d, input bit f);
      row_type r;
      r.data = d; r.fin = f; r.typed = 0; r.rsp = '0;
      rows.push_back(r);
   endfunction

   function automatic void add_typed(input logic [7:0] d, input rsp_type want);
      row_type r;
      r.data = d; r.fin = 0; r.typed = 1; r.rsp = want;
      rows.push_back(r);
   endfunction

   function automatic void add_nal(input bit four, input logic [7:0] hdr, input int len);
      if (four) add_row(8'h00, 0);
      add_row(8'h00, 0); add_row(8'h00, 0); add_row(8'h01, 0);
      add_row(hdr, 0);
      for (int i = 1; i < len; i++) begin
         case ($urandom_range(0, 5))
            0: add_row(8'h00, 0);
            1: add_row(8'h80 | 8'($urandom_range(0, 127)), 0);
            2: add_row(8'h01, 0);
            default: add_row(8'($urandom_range(0, 255)), 0);
         endcase
      end
   endfunction

   function automatic logic [7:0] slice_header();
      logic [7:0] h;
      case ($urandom_range(0, 3))
         0: h = {1'b0, 2'($urandom_range(0, 3)), NT_SLICE};
         1: h = {1'b0, 2'($urandom_range(0, 3)), NT_IDR};
         2: h = {1'b0, 2'($urandom_range(0, 3)), 5'($urandom_range(6, 8))};
         default: h = 8'($urandom_range(0, 255));
      endcase
      return h;
   endfunction

   task automatic send(input req_type q);
      push <= 1;
      req_data <= q;
      @(posedge clock);
      while (full) @(posedge clock);
      predict_nal_split(q);
   endtask

   task automatic gap();
      if (!tx_calm && $urandom_range(0, 99) < 14) begin
         push <= 0;
         @(posedge clock);
      end
   endtask

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (expected_rsp.size() == 0) begin
            report("unexpected", rsp_data, '0);
         end else begin
            rsp_type w;
            w = expected_rsp.pop_front();
            if (rsp_data.out_byte !== w.out_byte) report("out_byte", rsp_data, w);
            if (rsp_data.first_of_nal !== w.first_of_nal) report("first", rsp_data, w);
            if (rsp_data.last_of_nal !== w.last_of_nal) report("last", rsp_data, w);
            if (rsp_data.prefix_len !== w.prefix_len) report("prefix", rsp_data, w);
            if (rsp_data.forbidden_zero !== w.forbidden_zero)
               report("forbid", rsp_data, w);
            if (rsp_data.ref_idc !== w.ref_idc) report("ref_idc", rsp_data, w);
            if (rsp_data.nal_type !== w.nal_type) report("nal_type", rsp_data, w);
            if (rsp_data.frame_kind !== w.frame_kind) report("kind", rsp_data, w);
            if (rsp_data.nal_length !== w.nal_length) report("length", rsp_data, w);
            if (rsp_data.length_overflow !== w.length_overflow)
               report("overflow", rsp_data, w);
            if (rsp_data.bad_start !== w.bad_start) report("bad_start", rsp_data, w);
         end
      end
      if (reset) pop <= 0;
      else if (rx_hold) pop <= 0;
      else pop <= rx_calm || ($urandom_range(0, 99) >= 14);
   end

   initial begin
      rsp_type bad_rsp;
      req_type q;
      int      n;
      error_count = 0;
      idle_count = 0;
      rx_hold = 0; rx_calm = 0; tx_calm = 0;
      reset = 1;
      push = 0;
      req_data = '0;
      pop = 0;
      parser_reset();
      repeat (8) @(posedge clock);
      reset <= 0;

      bad_rsp = '0;
      bad_rsp.bad_start = 1;
      add_typed(8'hFF, bad_rsp);
      add_row(8'h00, 0); add_row(8'h00, 0); add_row(8'h01, 0);
      add_row(8'h65, 0); add_row(8'h88, 0); add_row(8'h00, 0);
      add_row(8'h00, 0); add_row(8'h00, 0); add_row(8'h01, 0);
      add_row(8'hE1, 0); add_row(8'h00, 0); add_row(8'h00, 0);
      add_row(8'h00, 0); add_row(8'h00, 0); add_row(8'h00, 1);
      add_row(8'h00, 0); add_row(8'h00, 1);
      add_row(8'h00, 0); add_row(8'h00, 0); add_row(8'h01, 0);
      add_row(8'h00, 0); add_row(8'h00, 0); add_row(8'h01, 0);
      add_row(8'h41, 0); add_row(8'h00, 1);

      foreach (rows[i]) begin
         q.in_byte = rows[i].data;
         q.stream_end = rows[i].fin;
         n = expected_rsp.size();
         send(q);
         if (rows[i].typed && expected_rsp.size() == n + 1 &&
             expected_rsp[n] !== rows[i].rsp)
            report("table", expected_rsp[n], rows[i].rsp);
         gap();
      end

      // build random streams: mostly well-formed NALs, some noise
      rows.delete();
      while (rows.size() < NUM_RANDOM) begin
         case ($urandom_range(0, 9))
            0: for (int k = 0; k < 4; k++) add_row(8'($urandom_range(0, 255)), 0);
            1: add_row(8'h00, 1);
            2: add_nal(1'($urandom_range(0, 1)), slice_header(), 1);
            default: add_nal(1'($urandom_range(0, 1)), slice_header(),
                             $urandom_range(2, 12));
         endcase
      end
      add_row(8'h00, 1);

      n = 0;
      foreach (rows[i]) begin
         q.in_byte = rows[i].data;
         q.stream_end = rows[i].fin;
         tx_calm = (i >= 100 && i < 180);
         if (i == 200) begin
            rx_hold = 1;
            fork
               begin
                  repeat (300) @(posedge clock);
                  rx_hold = 0;
               end
            join_none
         end
         if (i == 320) begin
            push <= 0;
            while (expected_rsp.size() != 0) @(posedge clock);
         end
         if (i >= 250 && i < 330) rx_calm = 1;
         else rx_calm = 0;
         send(q);
         gap();
      end
      push <= 0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

// File: files.f
hw/rtl/abnsc_pkg.sv
hw/rtl/abnsc_front.sv
hw/rtl/abnsc_cmd_queue.sv
hw/rtl/abnsc_back.sv
hw/rtl/annexb_nal_splitter_classifier_core.sv
bench/tb_annexb_nal_splitter_classifier_core.sv
